[sv/oli_pkg.sv]
// ----------------------------------------------------------------------------
// oli_pkg
// shared types and constants for the ordered list block
// ----------------------------------------------------------------------------
package oli_pkg;

  localparam int unsigned CapacityDefault = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_READ   = 4'b1000
  } state_e;

  typedef struct packed {
    logic [1:0]   opcode;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]   status;
    logic signed [31:0] entry;
    logic         last;
  } res_t;

endpackage

[sv/ordered_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// insertion-ordered list of signed 32-bit values in one ram, with insert at
// tail, delete of the first match and read-out from head to tail
// ----------------------------------------------------------------------------
// latency: insert, and delete or read on an empty list, gives its result the
//   cycle after the start transfer; delete is busy while it searches, then
//   shifts down, and read-out gives one result a cycle from the read state on
// throughput: one command at a time, busy_o is high while a walk runs
// reset: count and sequencer clear at once; the ram holds no reset value
// results cannot be stalled: res_strobe_o marks each for exactly one cycle
module ordered_list_insert_delete #(
  parameter int unsigned CAPACITY = oli_pkg::CapacityDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  oli_pkg::in_t  in_i,
  output logic          res_strobe_o,
  output oli_pkg::res_t res_o
);

  import oli_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e         state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic signed [31:0] value_q, value_d;
  logic           strobe_q, strobe_d;
  res_t           res_q, res_d;

  // ram ports
  logic           we;
  logic [AW-1:0]  waddr;
  logic [31:0]    wdata;
  logic [AW-1:0]  raddr;
  logic [31:0]    rdata;

  // index plus one and plus two, wide enough to meet count
  logic [CW-1:0]  nxt1, nxt2;

  assign nxt1 = CW'(idx_q) + CW'(1);
  assign nxt2 = CW'(idx_q) + CW'(2);

  oli_ram #(
    .Width (32),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    value_d  = value_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = rdata;
    raddr    = '0;

    case (state_q)
      S_IDLE: begin
        // head read is issued here so the walk starts with data in hand
        raddr = '0;
        if (start_i) begin
          value_d = in_i.value;
          case (in_i.opcode)
            OP_INSERT: begin
              strobe_d     = 1'b1;
              res_d.entry  = '0;
              res_d.last   = 1'b1;
              if (count_q == CW'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else begin
                we           = 1'b1;
                waddr        = count_q[AW-1:0];
                wdata        = in_i.value;
                count_d      = count_q + CW'(1);
                res_d.status = ST_OK;
              end
            end
            OP_DELETE, OP_READ: begin
              if (count_q == '0) begin
                strobe_d     = 1'b1;
                res_d.status = ST_EMPTY;
                res_d.entry  = '0;
                res_d.last   = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = (in_i.opcode == OP_DELETE) ? S_SEARCH : S_READ;
              end
            end
            default: begin
              // unused opcode: no transfer of results, no state change
            end
          endcase
        end
      end

      S_SEARCH: begin
        // rdata holds entry idx_q; fetch the next one speculatively
        raddr = nxt1[AW-1:0];
        if (rdata == value_q) begin
          if (nxt1 == count_q) begin
            // match at the tail: nothing to close up
            count_d      = count_q - CW'(1);
            strobe_d     = 1'b1;
            res_d.status = ST_OK;
            res_d.entry  = '0;
            res_d.last   = 1'b1;
            state_d      = S_IDLE;
          end else begin
            state_d = S_SHIFT;
          end
        end else if (nxt1 == count_q) begin
          strobe_d     = 1'b1;
          res_d.status = ST_NOTFOUND;
          res_d.entry  = '0;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          idx_d = nxt1[AW-1:0];
        end
      end

      S_SHIFT: begin
        // rdata holds entry idx_q+1, moved down one place
        we    = 1'b1;
        waddr = idx_q;
        wdata = rdata;
        raddr = nxt2[AW-1:0];
        if (nxt2 == count_q) begin
          count_d      = count_q - CW'(1);
          strobe_d     = 1'b1;
          res_d.status = ST_OK;
          res_d.entry  = '0;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          idx_d = nxt1[AW-1:0];
        end
      end

      S_READ: begin
        raddr        = nxt1[AW-1:0];
        strobe_d     = 1'b1;
        res_d.status = ST_OK;
        res_d.entry  = rdata;
        res_d.last   = (nxt1 == count_q);
        if (nxt1 == count_q) begin
          state_d = S_IDLE;
        end else begin
          idx_d = nxt1[AW-1:0];
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    value_q <= value_d;
    res_q   <= res_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

[sv/oli_ram.sv]
// ----------------------------------------------------------------------------
// oli_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module oli_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[tb/list_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_checker
// watches the command and result channels of the ordered list, keeps its own
// copy of the list, works out the results each command must give and
// compares every result strobe against the oldest outstanding one
// ----------------------------------------------------------------------------
module list_checker #(
  parameter int unsigned CAPACITY = oli_pkg::CapacityDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  oli_pkg::in_t  in_i,
  input  logic          res_strobe_i,
  input  oli_pkg::res_t res_i,
  output int            fail_cnt_o,
  output int            pending_cnt_o,
  output int            checked_cnt_o,
  output int            full_cnt_o,
  output int            notfound_cnt_o
);

  import oli_pkg::*;

  logic signed [31:0] shadow_list [CAPACITY];
  int unsigned        shadow_len = 0;
  res_t               due_results [$];

  int fail_cnt     = 0;
  int checked_cnt  = 0;
  int full_cnt     = 0;
  int notfound_cnt = 0;

  assign fail_cnt_o     = fail_cnt;
  assign pending_cnt_o  = due_results.size();
  assign checked_cnt_o  = checked_cnt;
  assign full_cnt_o     = full_cnt;
  assign notfound_cnt_o = notfound_cnt;

  function automatic res_t make_result(status_e st, logic signed [31:0] ent, logic lst);
    res_t r;
    r.status = st;
    r.entry  = ent;
    r.last   = lst;
    return r;
  endfunction

  // update the list copy and queue up the results the command causes
  task automatic apply_command(input in_t cmd);
    int unsigned idx;
    case (cmd.opcode)
      OP_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          due_results.push_back(make_result(ST_FULL, '0, 1'b1));
          full_cnt++;
        end else begin
          shadow_list[shadow_len] = cmd.value;
          shadow_len++;
          due_results.push_back(make_result(ST_OK, '0, 1'b1));
        end
      end
      OP_DELETE: begin
        if (shadow_len == 0) begin
          due_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          idx = 0;
          while (idx < shadow_len && shadow_list[idx] !== cmd.value) idx++;
          if (idx == shadow_len) begin
            due_results.push_back(make_result(ST_NOTFOUND, '0, 1'b1));
            notfound_cnt++;
          end else begin
            for (; idx + 1 < shadow_len; idx++) shadow_list[idx] = shadow_list[idx + 1];
            shadow_len--;
            due_results.push_back(make_result(ST_OK, '0, 1'b1));
          end
        end
      end
      OP_READ: begin
        if (shadow_len == 0) begin
          due_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          for (idx = 0; idx < shadow_len; idx++) begin
            due_results.push_back(make_result(ST_OK, shadow_list[idx], idx + 1 == shadow_len));
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_result(input res_t got);
    res_t want;
    checked_cnt++;
    if (due_results.size() == 0) begin
      fail_cnt++;
      $display("%0t: unexpected result status=%0d entry=%0d last=%0d",
               $time, got.status, got.entry, got.last);
    end else begin
      want = due_results.pop_front();
      if (got.status !== want.status || got.entry !== want.entry || got.last !== want.last) begin
        fail_cnt++;
        $display("%0t: mismatch expected status=%0d entry=%0d last=%0d,",
                 $time, want.status, want.entry, want.last);
        $display("  actual status=%0d entry=%0d last=%0d",
                 got.status, got.entry, got.last);
      end
    end
  endtask

  // results first: a new command's results can only come in later cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_len = 0;
      due_results.delete();
    end else begin
      if (res_strobe_i) compare_result(res_i);
      if (start_i && !busy_i) apply_command(in_i);
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives the ordered list with a directed command sequence and then random
// phases that fill, drain and read the list; a checker module predicts and
// compares every result, this top gives the verdict
// ----------------------------------------------------------------------------
module tb_top;
  import oli_pkg::*;

  localparam int unsigned Capacity    = oli_pkg::CapacityDefault;
  localparam int          RandomItems = 290;
  localparam logic [1:0]  OpUnused    = 2'd3;   // code the block must ignore
  localparam int          DrainCycles = 64;     // well past a full delete walk
  localparam int          PoolSize    = 16;

  // traffic mix of one random phase
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN,
    MIX_READS
  } mix_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  in_t  in_i;
  logic res_strobe_o;
  res_t res_o;

  int fail_cnt, pending_cnt, checked_cnt, full_cnt, notfound_cnt;
  int items_sent = 0;

  // recently inserted values, so deletes mostly hit something
  logic signed [31:0] recent_vals [PoolSize];
  int                 recent_n  = 0;
  int                 recent_wr = 0;
  logic               no_idle   = 1'b0;
  mix_e               mix;
  int                 pick;
  logic [1:0]         op;

  always #1 clk_i = ~clk_i;

  ordered_list_insert_delete #(
    .CAPACITY (Capacity)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .in_i         (in_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  list_checker #(
    .CAPACITY (Capacity)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .in_i           (in_i),
    .res_strobe_i   (res_strobe_o),
    .res_i          (res_o),
    .fail_cnt_o     (fail_cnt),
    .pending_cnt_o  (pending_cnt),
    .checked_cnt_o  (checked_cnt),
    .full_cnt_o     (full_cnt),
    .notfound_cnt_o (notfound_cnt)
  );

  // mostly back to back, sometimes a short pause, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // extremes and a few small values that make duplicates likely
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      4, 5:    return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_delete_value();
    if (recent_n > 0 && $urandom_range(0, 3) != 0) begin
      return recent_vals[$urandom_range(0, recent_n - 1)];
    end
    return pick_value();
  endfunction

  // one command transfer; start stays high across busy, so a held command
  // meets every phase of the previous walk
  task automatic send_cmd(input logic [1:0] code, input logic signed [31:0] val);
    in_t cmd;
    int  gap;
    cmd.opcode = code;
    cmd.value  = val;
    start_i <= 1'b1;
    in_i    <= cmd;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    if (code == OP_INSERT) begin
      recent_vals[recent_wr] = val;
      recent_wr = (recent_wr + 1) % PoolSize;
      if (recent_n < PoolSize) recent_n++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      // idle with junk on the command bus
      start_i <= 1'b0;
      in_i    <= in_t'({2'($urandom_range(0, 3)), $urandom});
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    in_i    = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, extremes, duplicates, head and tail removal
    send_cmd(OP_READ,   '0);
    send_cmd(OP_DELETE, 32'sd7);                // empty, value not looked at
    send_cmd(OP_INSERT, 32'sh8000_0000);
    send_cmd(OP_INSERT, 32'sh7fff_ffff);
    send_cmd(OP_INSERT, 32'sd5);
    send_cmd(OP_INSERT, '0);
    send_cmd(OP_INSERT, 32'sd5);                // duplicate
    send_cmd(OP_INSERT, -32'sd1);
    send_cmd(OpUnused,  -32'sd1);               // ignored, no result
    send_cmd(OP_READ,   '0);
    send_cmd(OP_DELETE, 32'sd5);                // only the one nearer the head
    send_cmd(OP_DELETE, 32'sd42);               // not found
    send_cmd(OP_READ,   '0);
    send_cmd(OP_DELETE, 32'sh8000_0000);        // head
    send_cmd(OP_DELETE, -32'sd1);               // tail
    send_cmd(OP_READ,   '0);
    send_cmd(OP_DELETE, 32'sd5);
    send_cmd(OP_DELETE, 32'sh7fff_ffff);
    send_cmd(OP_DELETE, '0);                    // list empty again
    send_cmd(OpUnused,  '0);
    send_cmd(OP_READ,   '0);

    // random phases, each with its own traffic mix and idling on or off
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 30 == 0) begin
        mix     = mix_e'($urandom_range(0, 3));
        no_idle = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        op = OpUnused;
      end else begin
        case (mix)
          MIX_FILL:  op = (pick < 70) ? OP_INSERT : (pick < 85) ? OP_DELETE : OP_READ;
          MIX_DRAIN: op = (pick < 20) ? OP_INSERT : (pick < 80) ? OP_DELETE : OP_READ;
          MIX_EVEN:  op = (pick < 40) ? OP_INSERT : (pick < 80) ? OP_DELETE : OP_READ;
          default:   op = (pick < 30) ? OP_INSERT : (pick < 60) ? OP_DELETE : OP_READ;
        endcase
      end
      if (op == OP_DELETE) send_cmd(op, pick_delete_value());
      else if (op == OP_INSERT) send_cmd(op, pick_value());
      else send_cmd(op, $urandom);
    end

    // let outstanding results arrive, then a quiet stretch
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("covered %0d commands and %0d results, list capacity %0d",
             items_sent, checked_cnt, Capacity);
    $display("inserts refused as full: %0d, deletes with no match: %0d",
             full_cnt, notfound_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #400_000;
    $display("timeout with %0d results outstanding", pending_cnt);
    $display("== FAIL ==");
    $finish;
  end

endmodule
